// File: rtl/cfe_pkg.sv
// shared constants and types of the continued fraction expander
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package cfe_pkg;

  // operand and coefficient width
  localparam int unsigned VALUE_BITS = 31;
  // longest expansion that is emitted, and the width of the term index
  localparam int unsigned MAX_TERMS  = 46;
  localparam int unsigned IDX_BITS   = 6;

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = ((2 * VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((VALUE_BITS + IDX_BITS + 7) / 8) * 8;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // divider bit counter
  localparam int unsigned BITCNT_W = $clog2(VALUE_BITS);

  typedef logic [VALUE_BITS-1:0] value_t;

  // one classified fraction
  typedef struct packed {
    logic   zero;  // numerator or denominator is zero
    value_t num;
    value_t den;
  } item_t;

  // queue handshake, producer side and consumer side
  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } pop_t;

endpackage

`default_nettype wire

// File: rtl/cfe_front.sv
// front end: takes fractions from the input stream, flags the zero case
// depends on cfe_pkg
`default_nettype none

module cfe_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // numerator [VALUE_BITS-1:0], denominator [2*VALUE_BITS-1:VALUE_BITS], zero padding
  input  wire logic [cfe_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output cfe_pkg::push_t                     push_o,
  input  wire logic                          push_ready_i
);

  logic           valid_q, valid_d;
  cfe_pkg::item_t item_q, item_d;
  cfe_pkg::value_t num, den;
  logic           take;

  assign num  = s_axis_tdata[cfe_pkg::VALUE_BITS-1:0];
  assign den  = s_axis_tdata[2*cfe_pkg::VALUE_BITS-1:cfe_pkg::VALUE_BITS];

  assign s_axis_tready = !valid_q || push_ready_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d  = item_q;
    valid_d = valid_q;
    if (take) begin
      item_d.num  = num;
      item_d.den  = den;
      item_d.zero = (num == '0) || (den == '0);
      valid_d     = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign push_o.valid = valid_q;
  assign push_o.item  = item_q;

endmodule

`default_nettype wire

// File: rtl/cfe_queue.sv
// short queue of classified fractions between front and back
// depends on cfe_pkg
`default_nettype none

module cfe_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cfe_pkg::push_t push_i,
  output logic                push_ready_o,
  output cfe_pkg::pop_t       pop_o,
  input  wire logic           pop_ready_i
);

  cfe_pkg::item_t                entry_q [cfe_pkg::QUEUE_DEPTH];
  logic [cfe_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [cfe_pkg::QCNT_W-1:0]    count_q;
  logic                          do_push, do_pop;

  assign push_ready_o = count_q != cfe_pkg::QCNT_W'(cfe_pkg::QUEUE_DEPTH);
  assign pop_o.valid  = count_q != '0;
  assign pop_o.item   = entry_q[rd_ptr_q];

  assign do_push = push_i.valid && push_ready_o;
  assign do_pop  = pop_o.valid && pop_ready_i;

  function automatic logic [cfe_pkg::QPTR_W-1:0] ptr_inc(logic [cfe_pkg::QPTR_W-1:0] p);
    ptr_inc = (p == cfe_pkg::QPTR_W'(cfe_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cfe_back.sv
// back end: euclid loop on a one-bit-per-cycle restoring divider,
// coefficients leave through an output register; depends on cfe_pkg
`default_nettype none

module cfe_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire cfe_pkg::pop_t                  pop_i,
  output logic                                pop_ready_o,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // term [VALUE_BITS-1:0], term_index [VALUE_BITS+IDX_BITS-1:VALUE_BITS], zero padding
  output logic [cfe_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam int unsigned VB = cfe_pkg::VALUE_BITS;

  logic [1:0]                      state_q, state_d;
  cfe_pkg::value_t                 quo_q, quo_d;   // dividend shifts out, quotient shifts in
  cfe_pkg::value_t                 rem_q, rem_d;
  cfe_pkg::value_t                 den_q, den_d;
  logic [cfe_pkg::BITCNT_W-1:0]    bit_q, bit_d;
  logic [cfe_pkg::IDX_BITS-1:0]    idx_q, idx_d;

  logic                            out_valid_q, out_valid_d;
  cfe_pkg::value_t                 out_term_q, out_term_d;
  logic [cfe_pkg::IDX_BITS-1:0]    out_idx_q, out_idx_d;
  logic                            out_last_q, out_last_d;

  logic [VB:0]                     rem_shift, rem_sub;
  logic                            fits;
  logic                            out_free;
  logic                            done;

  assign rem_shift = {rem_q, quo_q[VB-1]};
  assign rem_sub   = rem_shift - {1'b0, den_q};
  assign fits      = !rem_sub[VB];
  assign out_free  = !out_valid_q || m_axis_tready;
  assign done      = (rem_q == '0) ||
                     (idx_q >= cfe_pkg::IDX_BITS'(cfe_pkg::MAX_TERMS - 1));

  assign pop_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    den_d       = den_q;
    bit_d       = bit_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_term_d  = out_term_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (pop_i.valid) begin
          idx_d = '0;
          bit_d = cfe_pkg::BITCNT_W'(VB - 1);
          den_d = pop_i.item.den;
          if (pop_i.item.zero) begin
            // zero fraction: a single zero term with remainder zero
            quo_d   = '0;
            rem_d   = '0;
            state_d = ST_EMIT;
          end else begin
            quo_d   = pop_i.item.num;
            rem_d   = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d = fits ? rem_sub[VB-1:0] : rem_shift[VB-1:0];
        quo_d = {quo_q[VB-2:0], fits};
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_term_d  = quo_q;
          out_idx_d   = idx_q;
          out_last_d  = done;
          if (done) begin
            state_d = ST_IDLE;
          end else begin
            // next step divides the old divisor by the remainder
            quo_d   = den_q;
            den_d   = rem_q;
            rem_d   = '0;
            idx_d   = idx_q + 1'b1;
            bit_d   = cfe_pkg::BITCNT_W'(VB - 1);
            state_d = ST_DIV;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    den_q      <= den_d;
    bit_q      <= bit_d;
    idx_q      <= idx_d;
    out_term_q <= out_term_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = cfe_pkg::OUT_TDATA_W'({out_idx_q, out_term_q});

endmodule

`default_nettype wire

// File: rtl/continued_fraction_expander.sv
// top level of the continued fraction expander: front end, queue, back end
// depends on cfe_pkg, cfe_front, cfe_queue, cfe_back
`default_nettype none

// Takes one fraction numerator/denominator per input transaction and streams out
// its continued fraction coefficients in order, term_index counting from zero and
// tlast on the final one; a zero numerator or denominator gives the single term 0.
// Each coefficient comes from a restoring divider that retires one quotient bit per
// cycle while it divides; the term then waits in the emit state until the output
// register is free, and the divider takes no new fraction until the last term of
// the current one has been handed to that register. A front register and a two-entry
// queue keep accepting fractions while the divider works, and an output register
// holds a coefficient until the sink takes it.
module continued_fraction_expander (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // numerator [30:0], denominator [61:31], zero padding [63:62]
  input  wire logic [cfe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // term [30:0], term_index [36:31], zero padding [39:37]
  output logic [cfe_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // last
  output logic                                 m_axis_tlast
);

  cfe_pkg::push_t push;
  cfe_pkg::pop_t  pop;
  logic           push_ready;
  logic           pop_ready;

  cfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  cfe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .pop_o       (pop),
    .pop_ready_i (pop_ready)
  );

  cfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_i        (pop),
    .pop_ready_o  (pop_ready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

`default_nettype wire
